@@ hdl/kmsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared types and constants of the keypad matrix scanner with debounce.
// ----------------------------------------------------------------------------
package kmsd_pkg;

    // number of consecutive equal samples that settle a phase (2..64)
    localparam int SETTLE_READS = 16;
    localparam int RUN_W        = $clog2(SETTLE_READS + 1);

    localparam logic [3:0] PHASE_FIRST = 4'd7;
    localparam logic [3:0] PHASE_HIGH  = 4'd4;
    localparam logic [3:0] PHASE_SIDE  = 4'd8;

    localparam logic [7:0] ROW_MASK       = 8'hfe;
    localparam logic [7:0] SIDE_MASK      = 8'h71;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [7:0] side_sample;
        logic [7:0] row_sample;
    } sample_t;

    typedef struct packed {
        logic [63:0] key_matrix;
        logic        scan_done;
        logic [3:0]  drive_column;
    } result_t;

endpackage

@@ hdl/keypad_matrix_scan_debounce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce
// Scans an 8-column key matrix plus side keys with per-phase debounce.
// ----------------------------------------------------------------------------
//  channel   dir  signals                     contents
//  s_axis    in   tvalid tready tdata[15:0]   row_sample, side_sample
//  m_axis    out  tvalid tready tdata[71:0]   drive_column, key_matrix
//                 tuser[0]                    scan_done
//
// one result item per sample item, one item per cycle sustained while m_axis_tready stays high
// an item passes through the input register, then the step logic into the result register
// rst_n clears the scan to column 7 with an empty run and matrix
// a stalled result register holds its item while one more item waits in the input register
// ----------------------------------------------------------------------------
module keypad_matrix_scan_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // row_sample [7:0], side_sample [15:8]
    input  logic [kmsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drive_column [3:0], key_matrix [67:4], zero [71:68]
    output logic [kmsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // scan_done [0]
    output logic                               m_axis_tuser
);

    logic              item_valid;
    logic              take;
    kmsd_pkg::sample_t item;
    kmsd_pkg::result_t result;

    kmsd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    kmsd_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (result)
    );

    kmsd_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item_valid),
        .result        (result),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ hdl/kmsd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_in_stage
// Input register: holds one accepted pin sample until the step logic takes it.
// ----------------------------------------------------------------------------
module kmsd_in_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [kmsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                               take,
    output logic                               item_valid,
    output kmsd_pkg::sample_t                  item
);

    logic              valid_reg;
    logic              valid_next;
    kmsd_pkg::sample_t item_reg;
    logic              load;

    assign s_axis_tready = !valid_reg || take;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign valid_next    = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.row_sample  <= s_axis_tdata[7:0];
            item_reg.side_sample <= s_axis_tdata[15:8];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/kmsd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_step
// Scan state, debounce counter and matrix assembly for one sample.
// ----------------------------------------------------------------------------
module kmsd_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  kmsd_pkg::sample_t item,
    output kmsd_pkg::result_t result
);

    logic [3:0]                 phase_reg;
    logic [3:0]                 phase_next;
    logic [7:0]                 last_reg;
    logic [kmsd_pkg::RUN_W-1:0] run_reg;
    logic [kmsd_pkg::RUN_W-1:0] run_next;
    logic [31:0]                high_reg;
    logic [31:0]                high_next;
    logic [31:0]                low_reg;
    logic [31:0]                low_next;

    logic [3:0]                 phase;
    logic [7:0]                 masked;
    logic [7:0]                 pressed;
    logic [kmsd_pkg::RUN_W-1:0] run_upd;
    logic                       settled;
    logic                       done;
    logic [31:0]                high_side;

    always_comb
    begin
        // unreachable phase codes fall back to column 7
        phase = (phase_reg > kmsd_pkg::PHASE_SIDE) ? kmsd_pkg::PHASE_FIRST : phase_reg;
        masked = (phase == kmsd_pkg::PHASE_SIDE) ? (item.side_sample & kmsd_pkg::SIDE_MASK)
                                                 : (item.row_sample & kmsd_pkg::ROW_MASK);
        pressed = (~masked) & kmsd_pkg::ROW_MASK;

        if ((run_reg == '0) || (masked != last_reg))
            run_upd = kmsd_pkg::RUN_W'(1);
        else if (run_reg < kmsd_pkg::RUN_W'(kmsd_pkg::SETTLE_READS))
            run_upd = run_reg + kmsd_pkg::RUN_W'(1);
        else
            run_upd = run_reg;

        settled   = (run_upd >= kmsd_pkg::RUN_W'(kmsd_pkg::SETTLE_READS));
        // side keys are ORed over the upper four bits of the column 7 byte
        high_side = high_reg | {masked[0], masked[6:4], 28'd0};

        phase_next = phase;
        run_next   = run_upd;
        high_next  = high_reg;
        low_next   = low_reg;
        done       = 1'b0;

        if (settled)
        begin
            run_next = '0;
            if (phase == kmsd_pkg::PHASE_SIDE)
            begin
                done       = 1'b1;
                phase_next = kmsd_pkg::PHASE_FIRST;
                high_next  = '0;
                low_next   = '0;
            end
            else if (phase >= kmsd_pkg::PHASE_HIGH)
            begin
                high_next  = {high_reg[23:0], pressed};
                phase_next = phase - 4'd1;
            end
            else
            begin
                low_next   = {low_reg[23:0], pressed};
                phase_next = (phase == 4'd0) ? kmsd_pkg::PHASE_SIDE : phase - 4'd1;
            end
        end

        result.drive_column = phase_next;
        result.scan_done    = done;
        result.key_matrix   = done ? {high_side, low_reg} : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kmsd_pkg::PHASE_FIRST;
            last_reg  <= '0;
            run_reg   <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            last_reg  <= masked;
            run_reg   <= run_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

endmodule

@@ hdl/kmsd_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_out_stage
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module kmsd_out_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  kmsd_pkg::result_t                  result,
    output logic                               take,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [kmsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser
);

    logic              valid_reg;
    logic              valid_next;
    kmsd_pkg::result_t result_reg;

    // a new result may enter when the register is empty or being drained
    assign take       = in_valid && (!valid_reg || m_axis_tready);
    assign valid_next = take || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, result_reg.key_matrix, result_reg.drive_column};
    assign m_axis_tuser  = result_reg.scan_done;

endmodule
